/* design/pic_pkg.sv */
package pic_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned RGB_W  = 3 * CHAN_W;

  localparam logic [CHAN_W-1:0] CHAN_ZERO = '0;
  localparam logic [CHAN_W-1:0] CHAN_FULL = '1;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_CONVERT = 2'd1,
    REQ_CLEAR   = 2'd2,
    REQ_EXPAND  = 2'd3
  } req_kind_t;

  // one item as it travels down the cell row
  typedef struct packed {
    logic              valid;
    req_kind_t         kind;
    logic [IDX_W-1:0]  idx;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              found;
    logic [IDX_W-1:0]  hit;
  } pic_token_t;

endpackage

/* design/pic_cell.sv */
module pic_cell import pic_pkg::*; #(
  parameter int unsigned CELL_INDEX = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  pic_token_t tok_i,
  output pic_token_t tok_o
);

  localparam logic [IDX_W-1:0] SLOT = IDX_W'(CELL_INDEX);

  logic [RGB_W-1:0] color;
  logic             entry_valid;
  pic_token_t       tok_next;
  logic             slot_sel;
  logic             color_hit;

  assign slot_sel  = (tok_i.idx == SLOT);
  assign color_hit = entry_valid && (color == {tok_i.red, tok_i.green, tok_i.blue});

  always_comb begin
    tok_next = tok_i;
    case (tok_i.kind)
      REQ_CONVERT: begin
        // later cells overwrite, so the highest index wins
        if (color_hit) begin
          tok_next.found = 1'b1;
          tok_next.hit   = SLOT;
        end
      end
      REQ_EXPAND: begin
        if (slot_sel && entry_valid) begin
          tok_next.found = 1'b1;
          tok_next.red   = color[RGB_W-1 -: CHAN_W];
          tok_next.green = color[CHAN_W +: CHAN_W];
          tok_next.blue  = color[CHAN_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_o <= '0;
    end else begin
      tok_o <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (tok_i.valid) begin
      if (tok_i.kind == REQ_LOAD && slot_sel) begin
        entry_valid <= 1'b1;
      end else if (tok_i.kind == REQ_CLEAR) begin
        entry_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_i.valid && tok_i.kind == REQ_LOAD && slot_sel) begin
      color <= {tok_i.red, tok_i.green, tok_i.blue};
    end
  end

endmodule

/* design/pic_out.sv */
module pic_out import pic_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  pic_token_t        tok_i,
  output logic              strobe,
  output logic [CHAN_W-1:0] out_red,
  output logic [CHAN_W-1:0] out_green,
  output logic [CHAN_W-1:0] out_blue,
  output logic [CHAN_W-1:0] out_alpha,
  output logic              missing,
  output logic              any_missing
);

  logic              strobe_next;
  logic              sticky_next;
  logic [CHAN_W-1:0] red_next;
  logic [CHAN_W-1:0] green_next;
  logic [CHAN_W-1:0] blue_next;
  logic [CHAN_W-1:0] alpha_next;
  logic              missing_next;

  always_comb begin
    strobe_next  = 1'b0;
    sticky_next  = any_missing;
    red_next     = tok_i.red;
    green_next   = tok_i.green;
    blue_next    = tok_i.blue;
    alpha_next   = tok_i.alpha;
    missing_next = 1'b0;
    case (tok_i.kind)
      REQ_CONVERT: begin
        strobe_next = tok_i.valid;
        if (tok_i.alpha == CHAN_ZERO) begin
          // transparent: pass through
        end else if (tok_i.found) begin
          red_next   = tok_i.hit;
          green_next = CHAN_ZERO;
          blue_next  = CHAN_ZERO;
        end else begin
          red_next     = CHAN_FULL;
          green_next   = CHAN_ZERO;
          blue_next    = CHAN_FULL;
          alpha_next   = CHAN_FULL;
          missing_next = 1'b1;
          if (tok_i.valid) begin
            sticky_next = 1'b1;
          end
        end
      end
      REQ_EXPAND: begin
        strobe_next = tok_i.valid;
        if (!tok_i.found) begin
          red_next     = CHAN_ZERO;
          green_next   = CHAN_ZERO;
          blue_next    = CHAN_ZERO;
          missing_next = 1'b1;
        end
      end
      REQ_CLEAR: begin
        if (tok_i.valid) begin
          sticky_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe      <= 1'b0;
      any_missing <= 1'b0;
    end else begin
      strobe      <= strobe_next;
      any_missing <= sticky_next;
    end
  end

  always_ff @(posedge clk) begin
    out_red   <= red_next;
    out_green <= green_next;
    out_blue  <= blue_next;
    out_alpha <= alpha_next;
    missing   <= missing_next;
  end

endmodule

/* design/palette_index_converter_top.sv */
// Palette index converter: exact RGB match against a palette held in a row
// of cells, one entry per cell.
// Input: an item is taken on a rising edge with start high and busy low.
//   req_type selects load entry, convert pixel, clear palette, expand index.
// Output: convert and expand items give one result, shown for one cycle
//   with strobe high; load and clear give none. The receiver cannot stall.
// Every item walks the cell row, one cell per cycle, and each cell compares
//   or updates its own entry as the item passes, so items stay in order.
// From accept to strobe an item passes the register of every cell in the row
//   and then the result register.
// Throughput: one item per cycle while busy is low; busy is registered from
//   rst, so it is high only during reset and the cycle after it.
// Reset: all entries invalid, sticky any_missing flag cleared, items in
//   flight dropped.
module palette_index_converter_top import pic_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        req_type,
  input  logic [IDX_W-1:0]  entry_index,
  input  logic [CHAN_W-1:0] red,
  input  logic [CHAN_W-1:0] green,
  input  logic [CHAN_W-1:0] blue,
  input  logic [CHAN_W-1:0] alpha,
  output logic              strobe,
  output logic [CHAN_W-1:0] out_red,
  output logic [CHAN_W-1:0] out_green,
  output logic [CHAN_W-1:0] out_blue,
  output logic [CHAN_W-1:0] out_alpha,
  output logic              missing,
  output logic              any_missing
);

  pic_token_t tok [PALETTE_DEPTH+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_comb begin
    tok[0].valid = start && !busy;
    tok[0].kind  = req_kind_t'(req_type);
    tok[0].idx   = entry_index;
    tok[0].red   = red;
    tok[0].green = green;
    tok[0].blue  = blue;
    tok[0].alpha = alpha;
    tok[0].found = 1'b0;
    tok[0].hit   = '0;
  end

  for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
    pic_cell #(
      .CELL_INDEX(k)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .tok_i(tok[k]),
      .tok_o(tok[k+1])
    );
  end

  pic_out u_out (
    .clk        (clk),
    .rst        (rst),
    .tok_i      (tok[PALETTE_DEPTH]),
    .strobe     (strobe),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_alpha  (out_alpha),
    .missing    (missing),
    .any_missing(any_missing)
  );

`ifndef NO_ASSERTIONS
  a_strobe_from_row: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(tok[PALETTE_DEPTH].valid))
    else $error("result without an item leaving the cell row");

  a_miss_sets_sticky: assert property (@(posedge clk) disable iff (rst)
    strobe && missing && out_red == CHAN_FULL |-> any_missing)
    else $error("missing color did not set the sticky flag");

  a_miss_green_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && missing |-> out_green == CHAN_ZERO)
    else $error("missing result with nonzero green");

  a_busy_after_reset: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !busy)
    else $error("busy raised outside reset");
`endif

endmodule

/* bench/palette_index_converter_top_test.sv */
`timescale 1ns / 1ps

module palette_index_converter_top_test;
  import pic_pkg::*;

  localparam int unsigned PALETTE_DEPTH = 256;
  localparam int unsigned LATENCY = PALETTE_DEPTH + 1;
  localparam int unsigned LIMIT_CYCLES = 200000;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              missing;
    logic              any_missing;
  } pixel_result_t;

  class palette_mirror;
    logic [RGB_W-1:0] color [PALETTE_DEPTH];
    bit               valid [PALETTE_DEPTH];
    bit               written [PALETTE_DEPTH];
    bit               sticky;
    pixel_result_t    pending_pixels[$];
    int               errors;

    function new();
      foreach (valid[i]) begin
        valid[i] = 0;
        written[i] = 0;
        color[i] = '0;
      end
      sticky = 0;
      errors = 0;
    endfunction

    function void take_item(req_kind_t kind, logic [IDX_W-1:0] idx,
                            logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                            logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] a);
      logic [RGB_W-1:0] rgb;
      logic [IDX_W-1:0] hit;
      bit               found;
      int               i;
      pixel_result_t    res;
      rgb = {r, g, b};
      found = 0;
      hit = '0;
      case (kind)
        REQ_LOAD: begin
          if (idx < PALETTE_DEPTH) begin
            color[idx] = rgb;
            valid[idx] = 1;
            written[idx] = 1;
          end
        end
        REQ_CONVERT: begin
          if (a == CHAN_ZERO) begin
            res = '{r, g, b, a, 1'b0, sticky};
          end else begin
            for (i = 0; i < PALETTE_DEPTH; i++) begin
              if (valid[i] && color[i] == rgb) begin
                found = 1;
                hit = IDX_W'(i);
              end
            end
            if (found) begin
              res = '{hit, CHAN_ZERO, CHAN_ZERO, a, 1'b0, sticky};
            end else begin
              sticky = 1;
              res = '{CHAN_FULL, CHAN_ZERO, CHAN_FULL, CHAN_FULL, 1'b1, sticky};
            end
          end
          pending_pixels.push_back(res);
        end
        REQ_CLEAR: begin
          foreach (valid[j]) valid[j] = 0;
          sticky = 0;
        end
        default: begin
          if (idx < PALETTE_DEPTH && valid[idx]) begin
            res = '{color[idx][23:16], color[idx][15:8], color[idx][7:0], a, 1'b0, sticky};
          end else begin
            res = '{CHAN_ZERO, CHAN_ZERO, CHAN_ZERO, a, 1'b1, sticky};
          end
          pending_pixels.push_back(res);
        end
      endcase
    endfunction

    function void check_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $display("%0t: %s expected %0d got %0d", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void compare_result(pixel_result_t got);
      pixel_result_t exp;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result expected none got %h", $time, got);
        errors++;
      end else begin
        exp = pending_pixels.pop_front();
        check_field("out_red", exp.red, got.red);
        check_field("out_green", exp.green, got.green);
        check_field("out_blue", exp.blue, got.blue);
        check_field("out_alpha", exp.alpha, got.alpha);
        check_field("missing", exp.missing, got.missing);
        check_field("any_missing", exp.any_missing, got.any_missing);
      end
    endfunction
  endclass

  logic              clk = 0;
  logic              rst = 1;
  logic              start = 0;
  logic              busy;
  logic [1:0]        req_type = '0;
  logic [IDX_W-1:0]  entry_index = '0;
  logic [CHAN_W-1:0] red = '0;
  logic [CHAN_W-1:0] green = '0;
  logic [CHAN_W-1:0] blue = '0;
  logic [CHAN_W-1:0] alpha = '0;
  logic              strobe;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic [CHAN_W-1:0] out_alpha;
  logic              missing;
  logic              any_missing;

  palette_mirror     mirror;
  logic [RGB_W-1:0]  color_pool [8];
  int unsigned       cycles = 0;

  palette_index_converter_top #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .entry_index(entry_index),
    .red(red),
    .green(green),
    .blue(blue),
    .alpha(alpha),
    .strobe(strobe),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .out_alpha(out_alpha),
    .missing(missing),
    .any_missing(any_missing)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("palette_index_converter_top verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && strobe) begin
      mirror.compare_result('{out_red, out_green, out_blue, out_alpha, missing, any_missing});
    end
  end

  task automatic send_item(req_kind_t kind, logic [IDX_W-1:0] idx,
                           logic [RGB_W-1:0] rgb, logic [CHAN_W-1:0] a);
    @(negedge clk);
    start = 1;
    req_type = kind;
    entry_index = idx;
    red = rgb[23:16];
    green = rgb[15:8];
    blue = rgb[7:0];
    alpha = a;
    do @(posedge clk); while (busy);
    mirror.take_item(kind, idx, rgb[23:16], rgb[15:8], rgb[7:0], a);
  endtask

  task automatic idle_cycles(int unsigned n);
    @(negedge clk);
    start = 0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    start = 0;
    while (mirror.pending_pixels.size() != 0) @(posedge clk);
  endtask

  // nearest ever-written slot at or above idx, wrapping past the top, -1 if none
  function automatic int find_written(int unsigned idx);
    int k;
    for (k = 0; k < PALETTE_DEPTH; k++) begin
      if (mirror.written[(idx + k) % PALETTE_DEPTH]) return (idx + k) % PALETTE_DEPTH;
    end
    return -1;
  endfunction

  function automatic logic [RGB_W-1:0] pick_color();
    int unsigned w;
    w = $urandom_range(99);
    if (w < 50) return color_pool[$urandom_range(7)];
    if (w < 55) return '0;
    if (w < 60) return '1;
    return RGB_W'($urandom);
  endfunction

  function automatic logic [CHAN_W-1:0] pick_alpha();
    int unsigned w;
    w = $urandom_range(99);
    if (w < 12) return CHAN_ZERO;
    if (w < 22) return CHAN_FULL;
    return CHAN_W'($urandom_range(1, 254));
  endfunction

  task automatic random_item();
    int unsigned      w;
    int               slot;
    req_kind_t        kind;
    logic [IDX_W-1:0] idx;
    logic [RGB_W-1:0] rgb;
    logic [CHAN_W-1:0] a;
    w = $urandom_range(99);
    idx = IDX_W'($urandom);
    rgb = RGB_W'($urandom);
    a = CHAN_W'($urandom);
    if (w < 8) begin
      // noise: any field value, no clear
      kind = req_kind_t'($urandom_range(2));
      if (kind == REQ_CLEAR) kind = REQ_EXPAND;
      if (kind == REQ_EXPAND && !mirror.written[idx]) kind = REQ_CONVERT;
    end else if (w < 10) begin
      kind = REQ_CLEAR;
    end else if (w < 40) begin
      kind = REQ_LOAD;
      rgb = pick_color();
    end else if (w < 80) begin
      kind = REQ_CONVERT;
      a = pick_alpha();
      slot = find_written($urandom_range(PALETTE_DEPTH - 1));
      if (slot >= 0 && $urandom_range(99) < 55) rgb = mirror.color[slot];
      else rgb = pick_color();
    end else begin
      slot = find_written($urandom_range(PALETTE_DEPTH - 1));
      if (slot < 0) begin
        kind = REQ_LOAD;
        rgb = pick_color();
      end else begin
        kind = REQ_EXPAND;
        idx = IDX_W'(slot);
      end
    end
    send_item(kind, idx, rgb, a);
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned count);
    foreach (color_pool[i]) color_pool[i] = RGB_W'($urandom);
    repeat (count) begin
      if ($urandom_range(99) < idle_pct) idle_cycles($urandom_range(1, 4));
      random_item();
    end
  endtask

  initial begin
    mirror = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // empty palette: miss sets sticky, transparent pixel passes through
    send_item(REQ_CONVERT, 8'h00, 24'h0a141e, 8'h07);
    send_item(REQ_CONVERT, 8'hff, 24'hffffff, CHAN_ZERO);
    send_item(REQ_LOAD, 8'h00, 24'h000000, 8'h00);
    send_item(REQ_LOAD, 8'hff, 24'hffffff, 8'h00);
    send_item(REQ_LOAD, 8'h05, 24'h123456, 8'h00);
    send_item(REQ_LOAD, 8'hc8, 24'h123456, 8'h00);
    send_item(REQ_LOAD, 8'haa, 24'haa55aa, 8'h00);
    // hits, a miss and expands; duplicate color goes to the highest slot
    send_item(REQ_CONVERT, 8'h00, 24'h000000, CHAN_FULL);
    send_item(REQ_CONVERT, 8'h00, 24'hffffff, 8'h01);
    send_item(REQ_CONVERT, 8'h00, 24'h123456, 8'h80);
    send_item(REQ_CONVERT, 8'h00, 24'haa55aa, 8'h55);
    send_item(REQ_CONVERT, 8'h00, 24'habcdef, 8'h33);
    send_item(REQ_EXPAND, 8'h00, 24'h000000, CHAN_ZERO);
    send_item(REQ_EXPAND, 8'hff, 24'h000000, CHAN_FULL);
    send_item(REQ_EXPAND, 8'h05, 24'hffffff, 8'h42);
    send_item(REQ_EXPAND, 8'haa, 24'h000000, 8'h99);
    // clear drops entries and sticky
    send_item(REQ_CLEAR, 8'h00, 24'h000000, 8'h00);
    send_item(REQ_EXPAND, 8'hff, 24'h000000, 8'h66);
    send_item(REQ_CONVERT, 8'h00, 24'hffffff, CHAN_ZERO);
    send_item(REQ_LOAD, 8'h55, 24'hffffff, 8'h00);
    send_item(REQ_CONVERT, 8'h00, 24'hffffff, 8'h10);
    send_item(REQ_CONVERT, 8'h00, 24'h000000, 8'h10);
    send_item(REQ_EXPAND, 8'h55, 24'h000000, 8'hfe);
    send_item(REQ_CLEAR, 8'hff, 24'hffffff, CHAN_FULL);
    wait_drain();

    run_phase(0, 150);
    wait_drain();
    run_phase(50, 150);
    wait_drain();
    run_phase(0, 150);
    run_phase(20, 150);

    wait_drain();
    repeat (LATENCY + 8) @(posedge clk);
    if (mirror.pending_pixels.size() != 0) begin
      $display("%0t: results outstanding expected 0 got %0d", $time,
               mirror.pending_pixels.size());
      mirror.errors++;
    end
    if (mirror.errors == 0) begin
      $display("palette_index_converter_top verification clean");
    end else begin
      $display("palette_index_converter_top verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/pic_pkg.sv
design/pic_cell.sv
design/pic_out.sv
design/palette_index_converter_top.sv
bench/palette_index_converter_top_test.sv
